// ===== hw/rtl/cdq_pkg.sv =====
// Package for the circular deque: sizes, command and status codes, cell control.
package cdq_pkg;

   localparam int DEPTH     = 16;
   localparam int DATA_W    = 32;
   localparam int CMD_W     = 3;
   localparam int STATUS_W  = 2;
   localparam int CAP_W     = 5;
   localparam int OCC_W     = 5;
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int CAP_RESET = (16 > DEPTH) ? DEPTH : 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_REAR  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_REAR   = 3'd3,
      CMD_PEEK_FRONT = 3'd4,
      CMD_PEEK_REAR  = 3'd5
   } cdq_cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } cdq_status_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_SHIFT_IN,
      OP_FILL_REAR,
      OP_SHIFT_OUT,
      OP_DROP_REAR,
      OP_CLEAR
   } cdq_op_type;

   typedef struct packed {
      cdq_op_type              op;
      logic signed [DATA_W-1:0] push_value;
   } cdq_cell_ctrl_type;

endpackage

// ===== hw/rtl/cdq_req_if.sv =====
// Command channel: valid/ready handshake carrying cmd and value.
interface cdq_req_if import cdq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         cmd;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

// ===== hw/rtl/cdq_rsp_if.sv =====
// Result channel: valid/ready handshake carrying status, data and occupancy.
interface cdq_rsp_if import cdq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   cdq_status_type           status;
   logic signed [DATA_W-1:0] data;
   logic [OCC_W-1:0]         occupancy;

   modport source (output valid, output status, output data, output occupancy, input ready);
   modport sink   (input valid, input status, input data, input occupancy, output ready);
endinterface

// ===== hw/rtl/cdq_cell.sv =====
// One deque slot: holds an element and its occupied bit, shifts with its neighbors.
module cdq_cell import cdq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cdq_cell_ctrl_type        ctrl,
   input  logic signed [DATA_W-1:0] left_data,
   input  logic                     left_occ,
   input  logic signed [DATA_W-1:0] right_data,
   input  logic                     right_occ,
   output logic signed [DATA_W-1:0] data,
   output logic                     occ
);

   logic signed [DATA_W-1:0] data_ff, data_in;
   logic                     occ_ff, occ_in;

   always_comb begin
      data_in = data_ff;
      occ_in  = occ_ff;
      unique case (ctrl.op)
         OP_HOLD: begin
         end
         OP_SHIFT_IN: begin
            data_in = left_data;
            occ_in  = left_occ;
         end
         OP_FILL_REAR: begin
            if (left_occ && !occ_ff) begin
               data_in = ctrl.push_value;
               occ_in  = 1'b1;
            end
         end
         OP_SHIFT_OUT: begin
            data_in = right_data;
            occ_in  = right_occ;
         end
         OP_DROP_REAR: begin
            if (occ_ff && !right_occ) begin
               occ_in = 1'b0;
            end
         end
         OP_CLEAR: begin
            occ_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
      data_ff <= data_in;
   end

   assign data = data_ff;
   assign occ  = occ_ff;

endmodule

// ===== hw/rtl/circular_deque.sv =====
// Top level of the double-ended queue: command decode, cell row, result register.
// A result is registered and valid in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle unless stalled; every command is one update of the cell row.
// req ready is low only while a result waits and rsp ready is low.
// Reset empties the queue and sets capacity to 16; no clearing pass is needed.
module circular_deque import cdq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   cdq_req_if.sink          req_ch,
   cdq_rsp_if.source        rsp_ch,
   input  logic             csr_we,
   input  logic [CAP_W-1:0] csr_wdata
);

   logic signed [DATA_W-1:0] cell_data  [DEPTH];
   logic signed [DATA_W-1:0] left_data  [DEPTH];
   logic signed [DATA_W-1:0] right_data [DEPTH];
   logic [DEPTH-1:0]         occ, left_occ, right_occ, last_mask;

   logic [CNT_W-1:0]         count_ff, count_in, cap_ff, cap_in, count_res;
   logic                     rsp_valid_ff, rsp_valid_in;
   cdq_status_type           status_ff, status_in;
   logic signed [DATA_W-1:0] data_ff, data_in, rear_data;
   logic [OCC_W-1:0]         occ_out_ff, occ_out_in;
   cdq_cell_ctrl_type        ctrl;
   cdq_op_type               op_res;
   logic                     accept, full, empty;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign full         = count_ff >= cap_ff;
   assign empty        = count_ff == '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_data[i] = req_ch.value;
         assign left_occ[i]  = 1'b1;
      end else begin : g_mid
         assign left_data[i] = cell_data[i-1];
         assign left_occ[i]  = occ[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_data[i] = '0;
         assign right_occ[i]  = 1'b0;
      end else begin : g_inner
         assign right_data[i] = cell_data[i+1];
         assign right_occ[i]  = occ[i+1];
      end
      assign last_mask[i] = occ[i] && !right_occ[i];

      cdq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .left_data  (left_data[i]),
         .left_occ   (left_occ[i]),
         .right_data (right_data[i]),
         .right_occ  (right_occ[i]),
         .data       (cell_data[i]),
         .occ        (occ[i])
      );
   end

   always_comb begin
      rear_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (last_mask[i]) begin
            rear_data = rear_data | cell_data[i];
         end
      end
   end

   always_comb begin
      op_res    = OP_HOLD;
      status_in = ST_DONE;
      data_in   = '0;
      count_res = count_ff;
      unique case (req_ch.cmd) inside
         CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               op_res    = (req_ch.cmd == CMD_PUSH_FRONT) ? OP_SHIFT_IN : OP_FILL_REAR;
               count_res = count_ff + CNT_W'(1);
            end
         end
         CMD_POP_FRONT, CMD_POP_REAR, CMD_PEEK_FRONT, CMD_PEEK_REAR: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               data_in = (req_ch.cmd == CMD_POP_FRONT || req_ch.cmd == CMD_PEEK_FRONT) ?
                         cell_data[0] : rear_data;
               if (req_ch.cmd == CMD_POP_FRONT) begin
                  op_res    = OP_SHIFT_OUT;
                  count_res = count_ff - CNT_W'(1);
               end else if (req_ch.cmd == CMD_POP_REAR) begin
                  op_res    = OP_DROP_REAR;
                  count_res = count_ff - CNT_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      ctrl.push_value = req_ch.value;
      ctrl.op         = OP_HOLD;
      count_in        = count_ff;
      cap_in          = cap_ff;
      if (csr_we) begin
         ctrl.op  = OP_CLEAR;
         count_in = '0;
         if (csr_wdata == '0) begin
            cap_in = CNT_W'(1);
         end else if (32'(csr_wdata) > DEPTH) begin
            cap_in = CNT_W'(DEPTH);
         end else begin
            cap_in = CNT_W'(csr_wdata);
         end
      end else if (accept) begin
         ctrl.op  = op_res;
         count_in = count_res;
      end
   end

   assign occ_out_in   = OCC_W'(count_res);
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= CNT_W'(CAP_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         status_ff  <= status_in;
         data_ff    <= data_in;
         occ_out_ff <= occ_out_in;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = status_ff;
   assign rsp_ch.data      = data_ff;
   assign rsp_ch.occupancy = occ_out_ff;

   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) == $countones(occ))
      else $error("count disagrees with occupied cells");

   a_cells_packed: assert property (@(posedge clock) disable iff (reset)
      $onehot({1'b0, occ} + {{DEPTH{1'b0}}, 1'b1}))
      else $error("occupied cells not contiguous from the front");

   a_within_capacity: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cap_ff)
      else $error("occupancy above capacity");

   a_full_refused: assert property (@(posedge clock) disable iff (reset)
      accept && full &&
      (req_ch.cmd == CMD_PUSH_FRONT || req_ch.cmd == CMD_PUSH_REAR)
      |=> rsp_ch.valid && rsp_ch.status == ST_FULL)
      else $error("push into full queue not refused");

   a_empty_refused: assert property (@(posedge clock) disable iff (reset)
      accept && empty &&
      (req_ch.cmd == CMD_POP_FRONT || req_ch.cmd == CMD_POP_REAR ||
       req_ch.cmd == CMD_PEEK_FRONT || req_ch.cmd == CMD_PEEK_REAR)
      |=> rsp_ch.valid && rsp_ch.status == ST_EMPTY && rsp_ch.data == '0)
      else $error("read of empty queue not refused");

endmodule
